/* rtl/core/lpml_pkg.sv */
// shared types and constants for the longest prefix match lookup
`timescale 1ns / 1ps
`default_nettype none

package lpml_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int ID_W = (IDX_W > 4) ? IDX_W : 4;

  typedef enum logic [0:0] {
    KIND_WRITE  = 1'b0,
    KIND_LOOKUP = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [3:0]  entry_index;
    logic [31:0] entry_dest;
    logic [31:0] entry_mask;
    logic        entry_valid;
    logic [31:0] lookup_address;
  } req_t;

  typedef struct packed {
    logic        hit;
    logic [3:0]  match_index;
    logic [31:0] match_mask;
  } rsp_t;

  // route write broadcast to every cell
  typedef struct packed {
    logic        en;
    logic [3:0]  index;
    logic [31:0] dest;
    logic [31:0] mask;
    logic        valid;
  } wr_t;

  // lookup token handed from cell to cell
  typedef struct packed {
    logic        active;
    logic [31:0] address;
    logic        found;
    logic [3:0]  idx;
    logic [31:0] mask;
  } tok_t;

endpackage

`default_nettype wire

/* rtl/core/lpml_cell.sv */
// one route slot: holds an entry and updates the passing lookup token
`timescale 1ns / 1ps
`default_nettype none

module lpml_cell
  import lpml_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic [ID_W-1:0] cell_id,
  input  logic            advance,
  input  wr_t             wr,
  input  tok_t            tok_in,
  output tok_t            tok_out
);

  logic [31:0] dest;
  logic [31:0] mask;
  logic        valid;
  logic        match;
  logic        take;
  tok_t        tok_next;

  always_ff @(posedge clk) begin
    if (wr.en && (ID_W'(wr.index) == cell_id)) begin
      dest <= wr.dest;
      mask <= wr.mask;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (wr.en && (ID_W'(wr.index) == cell_id)) begin
      valid <= wr.valid;
    end
  end

  always_comb begin
    match = valid && ((tok_in.address & mask) == (dest & mask));
    take = match && (!tok_in.found || (mask > tok_in.mask));
    tok_next = tok_in;
    if (take) begin
      tok_next.found = 1'b1;
      tok_next.idx = cell_id[3:0];
      tok_next.mask = mask;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.active <= 1'b0;
    end else if (advance) begin
      tok_out.active <= tok_next.active;
    end
    if (advance) begin
      tok_out.address <= tok_next.address;
      tok_out.found <= tok_next.found;
      tok_out.idx <= tok_next.idx;
      tok_out.mask <= tok_next.mask;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/longest_prefix_match_lookup_top.sv */
// Longest prefix match route table of TABLE_ENTRIES slots, built as a row of cells that each
// hold one route. A write transaction updates its slot directly. A lookup transaction sends
// a token down the row, one cell per cycle while the row advances, and its result is then
// registered at the output; no new transaction is taken until that result is registered.
// The row holds while a finished token waits at its end because the output register still
// holds an earlier result that has not been taken.
// Valid marks clear at reset; destination and mask have no reset.
`timescale 1ns / 1ps
`default_nettype none

module longest_prefix_match_lookup_top
  import lpml_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  tok_t chain [TABLE_ENTRIES+1];
  wr_t  wr;
  logic busy;
  logic advance;
  logic accept;
  tok_t tail;

  assign req_ready = !busy;
  assign accept = req_valid && req_ready;
  assign tail = chain[TABLE_ENTRIES];
  assign advance = !(tail.active && rsp_valid && !rsp_ready);

  always_comb begin
    wr.en = accept && (req.kind == KIND_WRITE);
    wr.index = req.entry_index;
    wr.dest = req.entry_dest;
    wr.mask = req.entry_mask;
    wr.valid = req.entry_valid;
  end

  assign chain[0] = '{active: accept && (req.kind == KIND_LOOKUP),
                      address: req.lookup_address,
                      found: 1'b0,
                      idx: 4'd0,
                      mask: 32'd0};

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    lpml_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .cell_id (ID_W'(i)),
      .advance (advance),
      .wr      (wr),
      .tok_in  (chain[i]),
      .tok_out (chain[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (accept && (req.kind == KIND_LOOKUP)) begin
      busy <= 1'b1;
    end else if (advance && tail.active) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance && tail.active) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && tail.active) begin
      rsp.hit <= tail.found;
      rsp.match_index <= tail.idx;
      rsp.match_mask <= tail.mask;
    end
  end

endmodule

`default_nettype wire
